// ----- hw/rtl/assert_macros.svh -----
// assertion macros included by the downscaler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define BDSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true out of reset
`define BDSC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BDSC_ASSERT(lbl, prop, msg)
`define BDSC_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/bdsc_pkg.sv -----
// constants, types and tables of the box downscaler
package bdsc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RATIO  = 8;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // coordinate and size width, holds the largest size itself
  localparam int CW    = $clog2(MAX_DIM) + 1;
  // span edge width, one span past the size
  localparam int EW    = CW + 1;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int TW    = $clog2(MAX_RATIO + 1);
  localparam int RUN_W = $clog2((MAX_WIDTH / 2) * 255 + 1);
  localparam int SUM_W = $clog2((MAX_WIDTH / 2) * (MAX_HEIGHT / 2) * 255 + 1);
  localparam int REC_W = 13;
  localparam int T_W   = SUM_W + REC_W - 12;
  localparam int CFG_W = 13;
  localparam int IDX_W = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  // divider status toward the controller
  typedef struct packed {
    logic          busy;
    logic          done;
    logic [CW-1:0] quo;
    logic [CW-1:0] rem;
  } div_res_t;

  // 4096 / n for tap counts, zero taken as one
  function automatic logic [REC_W-1:0] recip(input logic [4:0] n);
    logic [REC_W-1:0] v;
    case (n)
      5'd0, 5'd1: v = 13'd4096;
      5'd2:  v = 13'd2048;
      5'd3:  v = 13'd1365;
      5'd4:  v = 13'd1024;
      5'd5:  v = 13'd819;
      5'd6:  v = 13'd682;
      5'd7:  v = 13'd585;
      5'd8:  v = 13'd512;
      5'd9:  v = 13'd455;
      5'd10: v = 13'd409;
      5'd11: v = 13'd372;
      5'd12: v = 13'd341;
      5'd13: v = 13'd315;
      5'd14: v = 13'd292;
      5'd15: v = 13'd273;
      default: v = 13'd256;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/bdsc_ram.sv -----
// generic single-port-write ram with registered read
module bdsc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bdsc_div.sv -----
// restoring divider for span quotient and remainder, one bit per cycle
module bdsc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [bdsc_pkg::CW-1:0] num,
  input  logic [bdsc_pkg::CW-1:0] den,
  output bdsc_pkg::div_res_t    res
);

  localparam int CW  = bdsc_pkg::CW;
  localparam int NW  = $clog2(CW + 1);

  logic [CW-1:0] q_r, q_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [CW-1:0] den_r;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW:0]   rem_sh;
  logic          fit;

  // one trial subtraction per cycle
  always_comb begin
    rem_sh   = {r_r, q_r[CW-1]};
    fit      = rem_sh >= {1'b0, den_r};
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      r_nxt    = '0;
      cnt_nxt  = NW'(CW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[CW-2:0], fit};
      r_nxt   = fit ? CW'(rem_sh - {1'b0, den_r}) : rem_sh[CW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.quo  = q_r;
  assign res.rem  = r_r;

endmodule

// ----- hw/rtl/box_downscale_bgra_to_i420_unit.sv -----
// box-filter downscaler from bgr pixels to bt.601 i420 samples
//
//  channel | ports                          | content
//  --------+--------------------------------+---------------------------------------
//  in      | in_tvalid/tready/tdata/tuser   | blue, green, red; tuser frame_start
//  out     | out_tvalid/tready/tdata/tuser  | luma, cb, cr, col, row; tuser chroma_valid,
//          | out_tlast                      | tlast frame_end
//  cfg     | cfg_we/cfg_index/cfg_wdata     | src/dst width and height
//
// a pixel that closes no column span passes acc and rowend; one that closes a
// span also does the read-modify-write of the column sum ram and cadv; one
// that completes a box adds mul1, mul2 with the two prev-row ram reads, luma, chr.
// after reset and after every config write the span divider runs for both
// axes with in_tready low; config writes are taken at any time.
// a result waits in the output register; the block stalls only when a new
// result is ready while the previous one is still not taken.
module box_downscale_bgra_to_i420_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // blue, green, red
  input  logic                       in_tuser,   // frame_start
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [47:0]                out_tdata,  // luma, cb, cr, out_col, out_row
  output logic                       out_tuser,  // chroma_valid
  output logic                       out_tlast,  // frame_end
  input  logic                       cfg_we,
  input  logic [bdsc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bdsc_pkg::CFG_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  localparam int CW    = bdsc_pkg::CW;
  localparam int EW    = bdsc_pkg::EW;
  localparam int AW    = bdsc_pkg::AW;
  localparam int TW    = bdsc_pkg::TW;
  localparam int RUN_W = bdsc_pkg::RUN_W;
  localparam int SUM_W = bdsc_pkg::SUM_W;
  localparam int REC_W = bdsc_pkg::REC_W;
  localparam int T_W   = bdsc_pkg::T_W;
  localparam int CFG_W = bdsc_pkg::CFG_W;
  localparam int P1_W  = SUM_W + REC_W;
  localparam int P2_W  = T_W + REC_W;

  typedef enum logic [12:0] {
    S_DSTC   = 13'b0000000000001,
    S_DWC    = 13'b0000000000010,
    S_DSTR   = 13'b0000000000100,
    S_DWR    = 13'b0000000001000,
    S_IDLE   = 13'b0000000010000,
    S_ACC    = 13'b0000000100000,
    S_CSUM   = 13'b0000001000000,
    S_MUL1   = 13'b0000010000000,
    S_MUL2   = 13'b0000100000000,
    S_LUMA   = 13'b0001000000000,
    S_CHR    = 13'b0010000000000,
    S_CADV   = 13'b0100000000000,
    S_ROWEND = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0] src_w_r, src_w_nxt, src_h_r, src_h_nxt;
  logic [CFG_W-1:0] dst_w_r, dst_w_nxt, dst_h_r, dst_h_nxt;
  logic [CW-1:0]    sw, sh, dw, dh;

  // span step values from the divider
  logic [CW-1:0] qc_r, qc_nxt, rc_r, rc_nxt, qr_r, qr_nxt, rr_r, rr_nxt;

  // position state
  logic [CW-1:0] src_col_r, src_col_nxt, src_row_r, src_row_nxt;
  logic [CW-1:0] dst_col_r, dst_col_nxt, dst_row_r, dst_row_nxt;
  logic [EW-1:0] col_edge_r, col_edge_nxt, row_edge_r, row_edge_nxt;
  logic [CW-1:0] col_rem_r, col_rem_nxt, row_rem_r, row_rem_nxt;
  logic [TW-1:0] col_taps_r, col_taps_nxt, row_taps_r, row_taps_nxt;
  logic [RUN_W-1:0] run_r [3];
  logic [RUN_W-1:0] run_nxt [3];
  logic [23:0]   even_rgb_r, even_rgb_nxt;

  // per-item work registers
  logic [7:0]       pix_r [3];
  logic             pix_fs_r;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [SUM_W-1:0] sum_r [3];
  logic [SUM_W-1:0] sum_nxt [3];
  logic [T_W-1:0]   t_r [3];
  logic [T_W-1:0]   t_nxt [3];
  logic [7:0]       avg_r [3];
  logic [7:0]       avg_nxt [3];
  logic [7:0]       ch_r [3];
  logic [7:0]       ch_nxt [3];
  logic [23:0]      a0_r, a0_nxt, a1_r, a1_nxt;
  logic [7:0]       y_r, y_nxt;
  logic             cv_r, cv_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic        out_user_r, out_user_nxt, out_last_r, out_last_nxt;

  // memories and divider
  logic                 col_we;
  logic [AW-1:0]        col_raddr;
  logic [3*SUM_W-1:0]   col_wdata, col_rdata;
  logic                 prev_we;
  logic [AW-1:0]        prev_raddr;
  logic [23:0]          prev_wdata, prev_rdata;
  logic                 div_start;
  logic [CW-1:0]        div_num, div_den;
  bdsc_pkg::div_res_t   div_res;

  // scratch values of the item logic
  logic             fs, close, last_row, row_close;
  logic [CW-1:0]    sc, dc, sr1, rt_base;
  logic [TW-1:0]    ct0, rt1, rt_sat;
  logic [EW-1:0]    edge_sum;
  logic [CW:0]      rem_sum;
  logic [SUM_W-1:0] mem_sum;
  logic [P1_W-1:0]  prod1 [3];
  logic [P2_W-1:0]  prod2 [3];
  logic [T_W:0]     scaled;
  logic [REC_W-1:0] xc, yc;
  logic [16:0]      ysum;
  logic [8:0]       yv;
  logic [9:0]       csum;
  logic [17:0]      cbs, crs;
  logic [7:0]       cbv, crv;

  // effective sizes, clamped so that upscaling never happens
  always_comb begin
    sw = (src_w_r < CFG_W'(2)) ? CW'(2) :
         (src_w_r > CFG_W'(bdsc_pkg::MAX_WIDTH)) ? CW'(bdsc_pkg::MAX_WIDTH) : CW'(src_w_r);
    sh = (src_h_r < CFG_W'(2)) ? CW'(2) :
         (src_h_r > CFG_W'(bdsc_pkg::MAX_HEIGHT)) ? CW'(bdsc_pkg::MAX_HEIGHT) : CW'(src_h_r);
    dw = (dst_w_r < CFG_W'(2)) ? CW'(2) :
         ({1'b0, dst_w_r} > (CFG_W+1)'(sw)) ? sw : CW'(dst_w_r);
    dh = (dst_h_r < CFG_W'(2)) ? CW'(2) :
         ({1'b0, dst_h_r} > (CFG_W+1)'(sh)) ? sh : CW'(dst_h_r);
  end

  // divider operands per axis
  assign div_start = (state_r == S_DSTC) || (state_r == S_DSTR);
  assign div_num   = (state_r == S_DSTC) ? sw : sh;
  assign div_den   = (state_r == S_DSTC) ? dw : dh;

  bdsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  bdsc_ram #(.W(3 * SUM_W), .D(bdsc_pkg::MAX_WIDTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (idx_r),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  bdsc_ram #(.W(24), .D(bdsc_pkg::MAX_WIDTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (idx_r),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  assign prev_raddr = (state_r == S_CSUM) ? idx_r - 1'b1 : idx_r;
  assign in_tready  = (state_r == S_IDLE);

  // controller and item datapath
  always_comb begin
    state_nxt    = state_r;
    src_w_nxt    = src_w_r;
    src_h_nxt    = src_h_r;
    dst_w_nxt    = dst_w_r;
    dst_h_nxt    = dst_h_r;
    qc_nxt       = qc_r;
    rc_nxt       = rc_r;
    qr_nxt       = qr_r;
    rr_nxt       = rr_r;
    src_col_nxt  = src_col_r;
    src_row_nxt  = src_row_r;
    dst_col_nxt  = dst_col_r;
    dst_row_nxt  = dst_row_r;
    col_edge_nxt = col_edge_r;
    row_edge_nxt = row_edge_r;
    col_rem_nxt  = col_rem_r;
    row_rem_nxt  = row_rem_r;
    col_taps_nxt = col_taps_r;
    row_taps_nxt = row_taps_r;
    even_rgb_nxt = even_rgb_r;
    idx_nxt      = idx_r;
    a0_nxt       = a0_r;
    a1_nxt       = a1_r;
    y_nxt        = y_r;
    cv_nxt       = cv_r;
    for (int c = 0; c < 3; c++) begin
      run_nxt[c] = run_r[c];
      sum_nxt[c] = sum_r[c];
      t_nxt[c]   = t_r[c];
      avg_nxt[c] = avg_r[c];
      ch_nxt[c]  = ch_r[c];
      prod1[c]   = '0;
      prod2[c]   = '0;
    end
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    col_we     = 1'b0;
    col_wdata  = '0;
    prev_we    = 1'b0;
    prev_wdata = {avg_r[2], avg_r[1], avg_r[0]};

    fs       = pix_fs_r;
    ct0      = fs ? '0 : col_taps_r;
    sc       = (fs ? '0 : src_col_r) + 1'b1;
    dc       = fs ? '0 : dst_col_r;
    close    = ({1'b0, sc} >= (fs ? EW'(qc_r) : col_edge_r)) || (sc >= sw);
    col_raddr = (dc >= CW'(bdsc_pkg::MAX_WIDTH)) ? AW'(bdsc_pkg::MAX_WIDTH - 1) : AW'(dc);
    last_row = ({1'b0, src_row_r} + 1'b1 >= row_edge_r) || (src_row_r + 1'b1 >= sh);
    rt_sat   = (row_taps_r < TW'(bdsc_pkg::MAX_RATIO)) ? row_taps_r + 1'b1 : row_taps_r;
    rt1      = rt_sat;
    rt_base  = CW'(rt_sat);
    sr1      = src_row_r + 1'b1;
    row_close = ({1'b0, sr1} >= row_edge_r) || (sr1 >= sh);
    xc       = bdsc_pkg::recip(5'(col_taps_r));
    yc       = bdsc_pkg::recip(5'(rt_base));
    edge_sum = '0;
    rem_sum  = '0;
    mem_sum  = '0;
    scaled   = '0;
    ysum     = '0;
    yv       = '0;
    csum     = '0;
    cbs      = '0;
    crs      = '0;
    cbv      = '0;
    crv      = '0;

    case (state_r)
      // span steps for the column axis, then the row axis
      S_DSTC: state_nxt = S_DWC;
      S_DWC: begin
        if (div_res.done) begin
          qc_nxt       = div_res.quo;
          rc_nxt       = div_res.rem;
          col_edge_nxt = EW'(div_res.quo);
          col_rem_nxt  = div_res.rem;
          state_nxt    = S_DSTR;
        end
      end
      S_DSTR: state_nxt = S_DWR;
      S_DWR: begin
        if (div_res.done) begin
          qr_nxt       = div_res.quo;
          rr_nxt       = div_res.rem;
          row_edge_nxt = EW'(div_res.quo);
          row_rem_nxt  = div_res.rem;
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_ACC;
        end
      end
      // frame restart, add the pixel to the running sum
      S_ACC: begin
        for (int c = 0; c < 3; c++) begin
          run_nxt[c] = (fs ? '0 : run_r[c]) + RUN_W'(pix_r[c]);
        end
        col_taps_nxt = (ct0 < TW'(bdsc_pkg::MAX_RATIO)) ? ct0 + 1'b1 : ct0;
        src_col_nxt  = sc;
        dst_col_nxt  = dc;
        idx_nxt      = col_raddr;
        if (fs) begin
          col_edge_nxt = EW'(qc_r);
          col_rem_nxt  = rc_r;
          src_row_nxt  = '0;
          dst_row_nxt  = '0;
          row_taps_nxt = '0;
          row_edge_nxt = EW'(qr_r);
          row_rem_nxt  = rr_r;
        end
        state_nxt = close ? S_CSUM : S_ROWEND;
      end
      // column sum read-modify-write
      S_CSUM: begin
        for (int c = 0; c < 3; c++) begin
          mem_sum    = col_rdata[c*SUM_W +: SUM_W];
          sum_nxt[c] = (row_taps_r == '0) ? SUM_W'(run_r[c]) : mem_sum + SUM_W'(run_r[c]);
        end
        col_we    = 1'b1;
        col_wdata = {sum_nxt[2], sum_nxt[1], sum_nxt[0]};
        state_nxt = last_row ? S_MUL1 : S_CADV;
      end
      // horizontal reciprocal
      S_MUL1: begin
        for (int c = 0; c < 3; c++) begin
          prod1[c] = P1_W'(sum_r[c]) * P1_W'(xc);
          t_nxt[c] = prod1[c][P1_W-1:12];
        end
        a0_nxt    = prev_rdata;
        state_nxt = S_MUL2;
      end
      // vertical reciprocal with saturation
      S_MUL2: begin
        for (int c = 0; c < 3; c++) begin
          prod2[c]   = P2_W'(t_r[c]) * P2_W'(yc);
          scaled     = prod2[c][P2_W-1:12];
          avg_nxt[c] = (scaled > (T_W+1)'(255)) ? 8'd255 : scaled[7:0];
        end
        a1_nxt    = prev_rdata;
        state_nxt = S_LUMA;
      end
      // luma, 2x2 chroma average, prev-row and even-column store
      S_LUMA: begin
        ysum = 17'd66 * 17'(avg_r[2]) + 17'd129 * 17'(avg_r[1]) +
               17'd25 * 17'(avg_r[0]) + 17'd128;
        yv   = (ysum[16:8] > 9'd255) ? 9'd255 : ysum[16:8];
        yv   = yv + 9'd16;
        y_nxt = (yv > 9'd255) ? 8'd255 : yv[7:0];
        for (int c = 0; c < 3; c++) begin
          csum = 10'(a0_r[c*8 +: 8]) + 10'(a1_r[c*8 +: 8]) +
                 10'(even_rgb_r[c*8 +: 8]) + 10'(avg_r[c]) + 10'd2;
          ch_nxt[c] = csum[9:2];
        end
        cv_nxt = dst_row_r[0] & dst_col_r[0];
        if (!dst_row_r[0]) begin
          prev_we = 1'b1;
        end
        if (!dst_col_r[0]) begin
          even_rgb_nxt = {avg_r[2], avg_r[1], avg_r[0]};
        end
        state_nxt = S_CHR;
      end
      // chroma and hand-off to the output register
      S_CHR: begin
        cbs = 18'd112 * 18'(ch_r[0]) + 18'd32896 - 18'd38 * 18'(ch_r[2]) -
              18'd74 * 18'(ch_r[1]);
        crs = 18'd112 * 18'(ch_r[2]) + 18'd32896 - 18'd94 * 18'(ch_r[1]) -
              18'd18 * 18'(ch_r[0]);
        cbv = (cbs[17:8] > 10'd255) ? 8'd255 : cbs[15:8];
        crv = (crs[17:8] > 10'd255) ? 8'd255 : crs[15:8];
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {dst_row_r[11:0], dst_col_r[11:0],
                           cv_r ? crv : 8'd0, cv_r ? cbv : 8'd0, y_r};
          out_user_nxt  = cv_r;
          out_last_nxt  = (dst_col_r + 1'b1 == dw) && (dst_row_r + 1'b1 == dh);
          state_nxt     = S_CADV;
        end
      end
      // close the column span
      S_CADV: begin
        for (int c = 0; c < 3; c++) begin
          run_nxt[c] = '0;
        end
        col_taps_nxt = '0;
        dst_col_nxt  = dst_col_r + 1'b1;
        edge_sum     = col_edge_r + EW'(qc_r);
        rem_sum      = {1'b0, col_rem_r} + {1'b0, rc_r};
        if (rem_sum >= {1'b0, dw}) begin
          rem_sum  = rem_sum - {1'b0, dw};
          edge_sum = edge_sum + 1'b1;
        end
        col_edge_nxt = edge_sum;
        col_rem_nxt  = rem_sum[CW-1:0];
        state_nxt    = S_ROWEND;
      end
      // end of source row, row span and frame wrap
      S_ROWEND: begin
        if (src_col_r >= sw) begin
          src_col_nxt  = '0;
          dst_col_nxt  = '0;
          col_taps_nxt = '0;
          for (int c = 0; c < 3; c++) begin
            run_nxt[c] = '0;
          end
          col_edge_nxt = EW'(qc_r);
          col_rem_nxt  = rc_r;
          row_taps_nxt = rt1;
          src_row_nxt  = sr1;
          if (row_close) begin
            row_taps_nxt = '0;
            dst_row_nxt  = dst_row_r + 1'b1;
            edge_sum     = row_edge_r + EW'(qr_r);
            rem_sum      = {1'b0, row_rem_r} + {1'b0, rr_r};
            if (rem_sum >= {1'b0, dh}) begin
              rem_sum  = rem_sum - {1'b0, dh};
              edge_sum = edge_sum + 1'b1;
            end
            row_edge_nxt = edge_sum;
            row_rem_nxt  = rem_sum[CW-1:0];
          end
          if (sr1 >= sh) begin
            src_row_nxt  = '0;
            dst_row_nxt  = '0;
            row_taps_nxt = '0;
            row_edge_nxt = EW'(qr_r);
            row_rem_nxt  = rr_r;
          end
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_DSTC;
    endcase

    // register write restarts counters and reruns the span divider
    if (cfg_we) begin
      case (cfg_index)
        bdsc_pkg::REG_SRC_WIDTH:  src_w_nxt = cfg_wdata;
        bdsc_pkg::REG_SRC_HEIGHT: src_h_nxt = cfg_wdata;
        bdsc_pkg::REG_DST_WIDTH:  dst_w_nxt = cfg_wdata;
        bdsc_pkg::REG_DST_HEIGHT: dst_h_nxt = cfg_wdata;
        default: ;
      endcase
      src_col_nxt  = '0;
      src_row_nxt  = '0;
      dst_col_nxt  = '0;
      dst_row_nxt  = '0;
      col_taps_nxt = '0;
      row_taps_nxt = '0;
      for (int c = 0; c < 3; c++) begin
        run_nxt[c] = '0;
      end
      state_nxt = S_DSTC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_DSTC;
      src_w_r     <= CFG_W'(1920);
      src_h_r     <= CFG_W'(1080);
      dst_w_r     <= CFG_W'(1920);
      dst_h_r     <= CFG_W'(1080);
      src_col_r   <= '0;
      src_row_r   <= '0;
      dst_col_r   <= '0;
      dst_row_r   <= '0;
      col_edge_r  <= '0;
      row_edge_r  <= '0;
      col_rem_r   <= '0;
      row_rem_r   <= '0;
      col_taps_r  <= '0;
      row_taps_r  <= '0;
      even_rgb_r  <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        run_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      src_w_r     <= src_w_nxt;
      src_h_r     <= src_h_nxt;
      dst_w_r     <= dst_w_nxt;
      dst_h_r     <= dst_h_nxt;
      src_col_r   <= src_col_nxt;
      src_row_r   <= src_row_nxt;
      dst_col_r   <= dst_col_nxt;
      dst_row_r   <= dst_row_nxt;
      col_edge_r  <= col_edge_nxt;
      row_edge_r  <= row_edge_nxt;
      col_rem_r   <= col_rem_nxt;
      row_rem_r   <= row_rem_nxt;
      col_taps_r  <= col_taps_nxt;
      row_taps_r  <= row_taps_nxt;
      even_rgb_r  <= even_rgb_nxt;
      out_valid_r <= out_valid_nxt;
      for (int c = 0; c < 3; c++) begin
        run_r[c] <= run_nxt[c];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pix_r[0] <= in_tdata[7:0];
      pix_r[1] <= in_tdata[15:8];
      pix_r[2] <= in_tdata[23:16];
      pix_fs_r <= in_tuser;
    end
    qc_r  <= qc_nxt;
    rc_r  <= rc_nxt;
    qr_r  <= qr_nxt;
    rr_r  <= rr_nxt;
    idx_r <= idx_nxt;
    a0_r  <= a0_nxt;
    a1_r  <= a1_nxt;
    y_r   <= y_nxt;
    cv_r  <= cv_nxt;
    for (int c = 0; c < 3; c++) begin
      sum_r[c] <= sum_nxt[c];
      t_r[c]   <= t_nxt[c];
      avg_r[c] <= avg_nxt[c];
      ch_r[c]  <= ch_nxt[c];
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // a finished result finds a free output register and lands there
  `BDSC_ASSERT(a_chr_load, (state_r == S_CHR) && !out_valid_r |=> out_valid_r, "result lost")
  // span remainders stay below the destination size between items
  `BDSC_ASSERT(a_rem_range, (state_r == S_IDLE) |-> (col_rem_r < dw) && (row_rem_r < dh), "rem range")
  // no pixel transfer while the span divider is running
  `BDSC_NEVER(a_acc_div, in_tvalid && in_tready && div_res.busy, "transfer during divide")
  // tap counters saturate
  `BDSC_NEVER(a_taps, (col_taps_r > TW'(bdsc_pkg::MAX_RATIO)) || (row_taps_r > TW'(bdsc_pkg::MAX_RATIO)), "taps")

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench of the box downscaler from bgr to i420 samples
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bdsc_pkg::IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [7:0]  luma;
    logic [7:0]  cb;
    logic [7:0]  cr;
    logic        cv;
    logic [11:0] col;
    logic [11:0] row;
    logic        fe;
  } yuv_sample_t;

  typedef struct { longint unsigned b, g, r; } bgr_sum_t;

  // pixel patterns of a test frame
  typedef enum int {
    PAT_BLACK  = 0,
    PAT_WHITE  = 1,
    PAT_STRIPE = 2,
    PAT_RANDOM = 3
  } pattern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;  // blue, green, red
  logic in_tuser = 1'b0;       // frame_start
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;      // luma, cb, cr, out_col, out_row
  logic out_tuser;             // chroma_valid
  logic out_tlast;             // frame_end
  logic cfg_we = 1'b0;
  logic [bdsc_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bdsc_pkg::CFG_W-1:0] cfg_wdata = '0;

  box_downscale_bgra_to_i420_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected samples and run bookkeeping
  yuv_sample_t pending_samples[$];
  int errors = 0;
  int pixels_sent = 0;
  int samples_seen = 0;
  int frames_sent = 0;
  int hold_cycles = 0;
  bit steady_rx = 1'b0;
  bit steady_tx = 1'b0;

  // shadow registers and scaler state
  int unsigned reg_sw, reg_sh, reg_dw, reg_dh;
  bgr_sum_t col_store[bdsc_pkg::MAX_WIDTH];
  int unsigned upper_rgb[bdsc_pkg::MAX_WIDTH];
  bgr_sum_t acc;
  int unsigned left_rgb;
  int unsigned s_col, s_row, d_col, d_row;
  int unsigned c_edge, r_edge, c_rem, r_rem, c_taps, r_taps;

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned eff_sw();
    return clip(reg_sw, 2, bdsc_pkg::MAX_WIDTH);
  endfunction
  function automatic int unsigned eff_sh();
    return clip(reg_sh, 2, bdsc_pkg::MAX_HEIGHT);
  endfunction
  function automatic int unsigned eff_dw();
    return clip(reg_dw, 2, eff_sw());
  endfunction
  function automatic int unsigned eff_dh();
    return clip(reg_dh, 2, eff_sh());
  endfunction

  function automatic int unsigned box_avg(longint unsigned sum, int unsigned xc,
                                          int unsigned yc);
    longint unsigned v;
    v = (((sum * xc) >> 12) * yc) >> 12;
    return v > 255 ? 255 : int'(v);
  endfunction

  function automatic int unsigned shift_sat(int unsigned v);
    v = v >> 8;
    return v > 255 ? 255 : v;
  endfunction

  task automatic restart_scan();
    s_col = 0; s_row = 0; d_col = 0; d_row = 0;
    c_taps = 0; r_taps = 0;
    acc = '{0, 0, 0};
    c_edge = eff_sw() / eff_dw(); c_rem = eff_sw() % eff_dw();
    r_edge = eff_sh() / eff_dh(); r_rem = eff_sh() % eff_dh();
  endtask

  task automatic advance_edge(inout int unsigned edg, inout int unsigned rm,
                              input int unsigned s, input int unsigned d);
    edg += s / d;
    rm += s % d;
    if (rm >= d) begin
      rm -= d;
      edg += 1;
    end
  endtask

  // advance the scaler by one source pixel, queue a sample when a box closes
  task automatic predict_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
    int unsigned sw, sh, dw, dh, idx, rt, xc, yc, ab, ag, ar, rgb, y;
    int unsigned a0, a1, bb, gg, rr;
    yuv_sample_t smp;
    sw = eff_sw(); sh = eff_sh(); dw = eff_dw(); dh = eff_dh();
    if (fs) restart_scan();
    acc.b += b; acc.g += g; acc.r += r;
    if (c_taps < bdsc_pkg::MAX_RATIO) c_taps++;
    s_col++;
    if (s_col >= c_edge || s_col >= sw) begin
      idx = d_col < bdsc_pkg::MAX_WIDTH ? d_col : bdsc_pkg::MAX_WIDTH - 1;
      if (r_taps == 0) col_store[idx] = acc;
      else begin
        col_store[idx].b += acc.b;
        col_store[idx].g += acc.g;
        col_store[idx].r += acc.r;
      end
      if (s_row + 1 >= r_edge || s_row + 1 >= sh) begin
        rt = r_taps < bdsc_pkg::MAX_RATIO ? r_taps + 1 : bdsc_pkg::MAX_RATIO;
        xc = 4096 / (c_taps != 0 ? c_taps : 1);
        yc = 4096 / rt;
        ab = box_avg(col_store[idx].b, xc, yc);
        ag = box_avg(col_store[idx].g, xc, yc);
        ar = box_avg(col_store[idx].r, xc, yc);
        rgb = ab | (ag << 8) | (ar << 16);
        y = shift_sat(66 * ar + 129 * ag + 25 * ab + 128) + 16;
        smp.cb = '0; smp.cr = '0; smp.cv = 1'b0;
        // odd row and odd column closes a 2x2 chroma block
        if (d_row[0] && d_col[0]) begin
          a0 = upper_rgb[idx - 1]; a1 = upper_rgb[idx];
          bb = ((a0 & 255) + (a1 & 255) + (left_rgb & 255) + ab + 2) >> 2;
          gg = (((a0 >> 8) & 255) + ((a1 >> 8) & 255) + ((left_rgb >> 8) & 255)
                + ag + 2) >> 2;
          rr = (((a0 >> 16) & 255) + ((a1 >> 16) & 255) + ((left_rgb >> 16) & 255)
                + ar + 2) >> 2;
          smp.cb = 8'(shift_sat(112 * bb + 128 + 32768 - 38 * rr - 74 * gg));
          smp.cr = 8'(shift_sat(112 * rr + 128 + 32768 - 94 * gg - 18 * bb));
          smp.cv = 1'b1;
        end
        if (!d_row[0]) upper_rgb[idx] = rgb;
        if (!d_col[0]) left_rgb = rgb;
        smp.luma = y > 255 ? 8'd255 : y[7:0];
        smp.col = d_col[11:0];
        smp.row = d_row[11:0];
        smp.fe = (d_col + 1 == dw) && (d_row + 1 == dh);
        pending_samples.push_back(smp);
      end
      acc = '{0, 0, 0};
      c_taps = 0;
      d_col++;
      advance_edge(c_edge, c_rem, sw, dw);
    end
    // end of source row and end of frame wrap
    if (s_col >= sw) begin
      s_col = 0; d_col = 0; c_taps = 0;
      acc = '{0, 0, 0};
      c_edge = sw / dw; c_rem = sw % dw;
      if (r_taps < bdsc_pkg::MAX_RATIO) r_taps++;
      s_row++;
      if (s_row >= r_edge || s_row >= sh) begin
        r_taps = 0;
        d_row++;
        advance_edge(r_edge, r_rem, sh, dh);
      end
      if (s_row >= sh) begin
        s_row = 0; d_row = 0; r_taps = 0;
        r_edge = sh / dh; r_rem = sh % dh;
      end
    end
  endtask

  // one pixel transfer on the input channel
  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
    while (!steady_tx && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r, g, b};
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    predict_pixel(b, g, r, fs);
    pixels_sent++;
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    end_burst();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic [bdsc_pkg::IDX_W-1:0] idx,
                           logic [bdsc_pkg::CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bdsc_pkg::REG_SRC_WIDTH:  reg_sw = val;
      bdsc_pkg::REG_SRC_HEIGHT: reg_sh = val;
      bdsc_pkg::REG_DST_WIDTH:  reg_dw = val;
      bdsc_pkg::REG_DST_HEIGHT: reg_dh = val;
      default: ;
    endcase
    restart_scan();
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw,
                              int unsigned dh);
    write_reg(bdsc_pkg::REG_SRC_WIDTH, bdsc_pkg::CFG_W'(sw));
    write_reg(bdsc_pkg::REG_SRC_HEIGHT, bdsc_pkg::CFG_W'(sh));
    write_reg(bdsc_pkg::REG_DST_WIDTH, bdsc_pkg::CFG_W'(dw));
    write_reg(bdsc_pkg::REG_DST_HEIGHT, bdsc_pkg::CFG_W'(dh));
  endtask

  task automatic send_frame(int unsigned n, pattern_t mode);
    logic [7:0] b, g, r;
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        PAT_BLACK: begin b = 8'd0; g = 8'd0; r = 8'd0; end
        PAT_WHITE: begin b = 8'd255; g = 8'd255; r = 8'd255; end
        PAT_STRIPE: begin
          b = i[0] ? 8'd255 : 8'd0; g = 8'd0; r = i[0] ? 8'd0 : 8'd255;
        end
        default: begin b = 8'($urandom); g = 8'($urandom); r = 8'($urandom); end
      endcase
      send_pixel(b, g, r, i == 0);
    end
    frames_sent++;
  endtask

  // reset geometry, extreme pixels, a write to an unused index and 4x4 to 2x2 frames
  task automatic test_directed();
    reg_sw = 1920; reg_sh = 1080; reg_dw = 1920; reg_dh = 1080;
    restart_scan();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    write_reg(REG_UNUSED, 13'h1FFF);
    set_geometry(4, 4, 2, 2);
    send_frame(16, PAT_BLACK);
    send_frame(16, PAT_WHITE);
    // registers out of range clamp to a 2x2 frame
    set_geometry(0, 1, 8191, 0);
    send_frame(4, PAT_STRIPE);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
  endtask

  // widest geometry, one box per pixel, receiver stalls once for a long stretch
  // while the sender keeps offering pixels without a gap
  task automatic test_widest();
    set_geometry(8191, 2, 4096, 2);
    steady_tx = 1'b1;
    steady_rx = 1'b1;
    hold_cycles = 400;
    send_frame(400, PAT_RANDOM);
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  // small random geometries, mostly whole frames, some broken or noisy
  task automatic test_random();
    int unsigned sw, sh, dw, dh, n, kind;
    while (pixels_sent < 650) begin
      sw = $urandom_range(2, 20);
      sh = $urandom_range(2, 18);
      dw = $urandom_range(1, sw / 2) * 2;
      dh = $urandom_range(1, sh / 2) * 2;
      if ($urandom_range(9) == 0) dw = $urandom_range(2, sw);
      if ($urandom_range(9) == 0) dh = $urandom_range(2, sh);
      set_geometry(sw, sh, dw, dh);
      steady_tx = $urandom_range(7) == 0;
      steady_rx = steady_tx;
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(9);
        n = sw * sh;
        if (kind == 0) send_frame($urandom_range(1, n), PAT_RANDOM);
        else if (kind == 1) begin
          for (int i = 0; i < 8; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(3) == 0);
        end else send_frame(n, PAT_RANDOM);
      end
      steady_tx = 1'b0;
      steady_rx = 1'b0;
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%t mismatch %s expected %0d actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver: compare each result transfer, then choose the next ready
  always @(posedge clk) begin
    yuv_sample_t e;
    if (rst_n && out_tvalid && out_tready) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        $display("%t unexpected sample, actual %h", $realtime, out_tdata);
        errors++;
      end else begin
        e = pending_samples.pop_front();
        check_field("luma", e.luma, out_tdata[7:0]);
        check_field("cb", e.cb, out_tdata[15:8]);
        check_field("cr", e.cr, out_tdata[23:16]);
        check_field("col", e.col, out_tdata[35:24]);
        check_field("row", e.row, out_tdata[47:36]);
        check_field("chroma_valid", e.cv, out_tuser);
        check_field("frame_end", e.fe, out_tlast);
      end
    end
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_tready <= steady_rx || ($urandom_range(99) >= 36);
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_widest();
    drain();
    $display("covered %0d pixels in %0d frames, %0d samples checked",
             pixels_sent, frames_sent, samples_seen);
    $display("geometries from clamped 2x2 to 4096 wide, tap saturation and odd sizes");
    if (errors == 0 && pending_samples.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bdsc_pkg.sv
hw/rtl/bdsc_ram.sv
hw/rtl/bdsc_div.sv
hw/rtl/box_downscale_bgra_to_i420_unit.sv
sim/tb_top.sv
